// ----- design/bta_pkg.sv -----
// Shared types and constants of the block table heap allocator.
`default_nettype none
package bta_pkg;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOROOM  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam int MARK_W         = 3;
    localparam int MARK_TAKEN_BIT = 0;
    localparam int MARK_FIRST_BIT = 1;
    localparam int MARK_NEXT_BIT  = 2;

    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    localparam int          ACTIVE_W     = 11;
    localparam logic [10:0] ACTIVE_RESET = 11'd1024;

    typedef struct packed {
        logic        req_type;
        logic [31:0] request_size;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic [1:0]  status;
    } rsp_t;

endpackage
`default_nettype wire

// ----- design/bta_ram.sv -----
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/bta_div.sv -----
// Block-count divider by a power-of-two constant with a registered result.
`default_nettype none
module bta_div #(
    parameter int DIVISOR = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [32:0] dividend,
    output logic             done,
    output logic      [32:0] quotient
);

    localparam int SHIFT = $clog2(DIVISOR);

    logic [32:0] quo_reg, quo_next;
    logic        done_reg, done_next;

    always_comb
    begin
        done_next = start;
        quo_next  = quo_reg;
        if (start)
        begin
            quo_next = dividend >> SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- design/block_table_heap_allocator.sv -----
// Top level of the block table heap allocator.
//
// A request is taken when start is high and busy is low; its single result word
// appears on rsp for exactly one cycle with done high, in the first cycle with busy
// low, and cannot be held off. BLOCK_BYTES must be a power of two. Every request
// first turns its size or address into a block count. An allocate then reads the
// mark table one entry per cycle from block zero until a free run of the needed
// length is found or the active entries run out, and writes one entry per cycle
// to mark the run. A free rewrites one entry per cycle along its chain. An
// allocate of zero blocks or of more blocks than are active, and an outside free,
// end in S_DIV without touching the table. After reset the table memory is
// cleared one entry per cycle, and busy stays high until every entry is cleared;
// configuration writes are accepted meanwhile.
`default_nettype none
module block_table_heap_allocator
    import bta_pkg::*;
#(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire req_t        req,
    output logic             busy,
    output logic             done,
    output rsp_t             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int IDXW = $clog2(NUM_BLOCKS);
    localparam int CNTW = $clog2(NUM_BLOCKS + 1);
    localparam int CMPW = (CNTW > ACTIVE_W) ? CNTW : ACTIVE_W;
    localparam logic [CMPW-1:0] NUM_CMP  = CMPW'(NUM_BLOCKS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_BLOCKS - 1);
    localparam logic [31:0]     BB32     = 32'(BLOCK_BYTES);
    localparam logic [32:0]     ROUND_UP = 33'(BLOCK_BYTES - 1);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SCAN0 = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_MARK  = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_CLR0  = 4'd7;
    localparam logic [3:0] S_CLR   = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [IDXW-1:0]     ptr_reg, ptr_next;
    logic [CNTW-1:0]     run_reg, run_next;
    logic [IDXW-1:0]     run_start_reg, run_start_next;
    logic [CNTW-1:0]     need_reg, need_next;
    logic [CNTW-1:0]     left_reg, left_next;
    logic                first_reg, first_next;
    logic [CNTW-1:0]     count_reg, count_next;
    logic                type_reg, type_next;
    logic [31:0]         prod_reg, prod_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;
    logic [31:0]         base_reg;
    logic [ACTIVE_W-1:0] active_reg;

    logic                accept;
    logic [CMPW-1:0]     active_cmp;
    logic [CNTW-1:0]     count_now;
    logic [32:0]         dividend;
    logic                div_done;
    logic [32:0]         quotient;
    logic                we;
    logic [IDXW-1:0]     waddr;
    logic [MARK_W-1:0]   wdata;
    logic [IDXW-1:0]     raddr;
    logic [MARK_W-1:0]   rdata;
    logic [CNTW-1:0]     ptr_inc;
    logic [CNTW-1:0]     run_inc;
    logic [IDXW-1:0]     cand_start;
    logic                cfg_write;

    assign accept     = start && !busy;
    assign busy       = state_reg != S_IDLE;
    assign active_cmp = CMPW'(active_reg);
    assign count_now  = (active_cmp > NUM_CMP) ? CNTW'(NUM_BLOCKS) : CNTW'(active_reg);
    assign dividend   = (req.req_type == REQ_ALLOC)
                        ? {1'b0, req.request_size} + ROUND_UP
                        : {1'b0, req.free_address - base_reg};
    assign ptr_inc    = CNTW'(ptr_reg) + CNTW'(1);
    assign run_inc    = run_reg + CNTW'(1);
    assign cand_start = (run_reg == '0) ? ptr_reg : run_start_reg;

    bta_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    bta_ram #(
        .WIDTH (MARK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_marks (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        need_next      = need_reg;
        left_next      = left_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        type_next      = type_reg;
        prod_next      = prod_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        we             = 1'b0;
        waddr          = ptr_reg;
        wdata          = '0;
        raddr          = ptr_reg + IDXW'(1);
        unique case (state_reg)
            S_INIT:
            begin
                we       = 1'b1;
                ptr_next = ptr_reg + IDXW'(1);
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    type_next  = req.req_type;
                    count_next = count_now;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (type_reg == REQ_ALLOC)
                    begin
                        if (quotient == '0 || quotient > 33'(count_reg))
                        begin
                            done_next  = 1'b1;
                            rsp_next   = '{result_address: '0, status: ST_NOROOM};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            need_next  = quotient[CNTW-1:0];
                            ptr_next   = '0;
                            run_next   = '0;
                            state_next = S_SCAN0;
                        end
                    end
                    else
                    begin
                        if (quotient >= 33'(count_reg))
                        begin
                            done_next  = 1'b1;
                            rsp_next   = '{result_address: '0, status: ST_OUTSIDE};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ptr_next   = quotient[IDXW-1:0];
                            state_next = S_CLR0;
                        end
                    end
                end
            end
            S_SCAN0:
            begin
                raddr      = ptr_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ptr_next = ptr_reg + IDXW'(1);
                if (!rdata[MARK_TAKEN_BIT] && run_inc == need_reg)
                begin
                    ptr_next   = cand_start;
                    left_next  = need_reg;
                    first_next = 1'b1;
                    state_next = S_MARK;
                end
                else
                begin
                    if (!rdata[MARK_TAKEN_BIT])
                    begin
                        run_next       = run_inc;
                        run_start_next = cand_start;
                    end
                    else
                    begin
                        run_next = '0;
                    end
                    if (ptr_inc == count_reg)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{result_address: '0, status: ST_NOROOM};
                        state_next = S_IDLE;
                    end
                end
            end
            S_MARK:
            begin
                we                    = 1'b1;
                wdata[MARK_TAKEN_BIT] = 1'b1;
                wdata[MARK_FIRST_BIT] = first_reg;
                wdata[MARK_NEXT_BIT]  = left_reg != CNTW'(1);
                first_next            = 1'b0;
                if (first_reg)
                begin
                    prod_next = 32'(ptr_reg * BB32);
                end
                ptr_next  = ptr_reg + IDXW'(1);
                left_next = left_reg - CNTW'(1);
                if (left_reg == CNTW'(1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                rsp_next   = '{result_address: base_reg + prod_reg, status: ST_OK};
                state_next = S_IDLE;
            end
            S_CLR0:
            begin
                raddr      = ptr_reg;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                we = 1'b1;
                if (rdata[MARK_NEXT_BIT] && ptr_inc < count_reg)
                begin
                    ptr_next = ptr_reg + IDXW'(1);
                end
                else
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{result_address: '0, status: ST_OK};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            ptr_reg    <= '0;
            done_reg   <= 1'b0;
            base_reg   <= '0;
            active_reg <= ACTIVE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                unique case (paddr[2])
                    REG_BASE:   base_reg   <= pwdata;
                    REG_ACTIVE: active_reg <= pwdata[ACTIVE_W-1:0];
                    default:    base_reg   <= base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        need_reg      <= need_next;
        left_reg      <= left_next;
        first_reg     <= first_next;
        count_reg     <= count_next;
        type_reg      <= type_next;
        prod_reg      <= prod_next;
        rsp_reg       <= rsp_next;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE) ? {{(32 - ACTIVE_W){1'b0}}, active_reg} : base_reg;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word presented while a request is still in work");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted request did not enter work");

    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MARK |-> CNTW'(ptr_reg) < count_reg && left_reg != '0)
        else $error("run marking beyond the active table");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.result_address == '0)
        else $error("failed request returned a nonzero address");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.status == ST_OK || rsp.status == ST_NOROOM || rsp.status == ST_OUTSIDE)
        else $error("result word carries an undefined status");
`endif

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the block table heap allocator: directed and random requests checked against a mark table predictor.
`default_nettype none
module tb;
    import bta_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_BYTES = 4096;
    localparam int CLK_PERIOD  = 10;

    localparam logic [2:0] ADDR_BASE   = {REG_BASE, 2'b00};
    localparam logic [2:0] ADDR_ACTIVE = {REG_ACTIVE, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    req_t        req = '0;
    logic        busy;
    logic        done;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [MARK_W-1:0]   marks_model [NUM_BLOCKS];
    logic [31:0]         base_model = '0;
    logic [ACTIVE_W-1:0] active_model = ACTIVE_RESET;

    req_t pending_req [$];
    rsp_t expected_rsp [$];
    rsp_t oldest_rsp;

    bit steady = 1'b0;
    int gap_left = 0;
    int n_pushed = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_settings = 0;
    int n_granted = 0;
    int n_refused = 0;
    int n_freed = 0;
    int n_outside = 0;

    block_table_heap_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .BLOCK_BYTES(BLOCK_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .busy(busy),
        .done(done),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            marks_model[i] = '0;
        end
    end

    function automatic int unsigned table_count();
        return (active_model > NUM_BLOCKS) ? NUM_BLOCKS : int'(active_model);
    endfunction

    function automatic rsp_t heap_predict(req_t r);
        rsp_t              res;
        int unsigned       count;
        logic [63:0]       need;
        int unsigned       run_len;
        int unsigned       run_start;
        int unsigned       idx;
        logic [31:0]       offset;
        logic [31:0]       blk;
        bit                found;
        bit                stop;
        logic [MARK_W-1:0] m;
        res.result_address = '0;
        res.status = ST_OK;
        count = table_count();
        if (r.req_type == REQ_ALLOC)
        begin
            need = ({32'd0, r.request_size} + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
            found = 1'b0;
            run_len = 0;
            run_start = 0;
            if (need != 0 && need <= 64'(count))
            begin
                for (idx = 0; idx < count && !found; idx++)
                begin
                    if (marks_model[idx][MARK_TAKEN_BIT])
                    begin
                        run_len = 0;
                    end
                    else
                    begin
                        if (run_len == 0)
                        begin
                            run_start = idx;
                        end
                        run_len++;
                        if (64'(run_len) == need)
                        begin
                            found = 1'b1;
                        end
                    end
                end
            end
            if (!found)
            begin
                res.status = ST_NOROOM;
                n_refused++;
            end
            else
            begin
                for (idx = 0; 64'(idx) < need; idx++)
                begin
                    m = '0;
                    m[MARK_TAKEN_BIT] = 1'b1;
                    m[MARK_FIRST_BIT] = (idx == 0);
                    m[MARK_NEXT_BIT] = (64'(idx + 1) < need);
                    marks_model[run_start + idx] = m;
                end
                res.result_address = base_model + 32'(run_start * BLOCK_BYTES);
                n_granted++;
            end
        end
        else
        begin
            offset = r.free_address - base_model;
            blk = offset / BLOCK_BYTES;
            if (blk >= count)
            begin
                res.status = ST_OUTSIDE;
                n_outside++;
            end
            else
            begin
                stop = 1'b0;
                for (idx = blk; idx < count && !stop; idx++)
                begin
                    m = marks_model[idx];
                    marks_model[idx] = '0;
                    stop = !m[MARK_NEXT_BIT];
                end
                n_freed++;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (steady || roll < 50)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return int'($urandom_range(1, 4));
        end
        if (roll < 97)
        begin
            return int'($urandom_range(5, 60));
        end
        return int'($urandom_range(200, 2500));
    endfunction

    task automatic note_mismatch(string text);
        n_mismatch++;
        if (n_mismatch <= 10)
        begin
            $display("MISMATCH at %0t: %s", $realtime, text);
        end
    endtask

    // A request word is predicted at the edge where the block takes it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rsp.push_back(heap_predict(req));
                n_accepted++;
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_req.size() > 0)
                begin
                    req <= pending_req.pop_front();
                    start <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (expected_rsp.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result word addr %h status %0d",
                    rsp.result_address, rsp.status));
            end
            else
            begin
                oldest_rsp = expected_rsp.pop_front();
                if (rsp.result_address !== oldest_rsp.result_address ||
                    rsp.status !== oldest_rsp.status)
                begin
                    note_mismatch($sformatf(
                        "expected addr %h status %0d, got addr %h status %0d",
                        oldest_rsp.result_address, oldest_rsp.status,
                        rsp.result_address, rsp.status));
                end
            end
        end
    end

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        mask = (addr == ADDR_ACTIVE) ? 32'((1 << ACTIVE_W) - 1) : 32'hffff_ffff;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (value & mask))
        begin
            note_mismatch($sformatf("register at %0d reads %h, written %h", addr, got, value));
        end
        if (addr == ADDR_BASE)
        begin
            base_model = value;
        end
        else
        begin
            active_model = value[ACTIVE_W-1:0];
        end
    endtask

    task automatic set_heap(logic [31:0] base, logic [ACTIVE_W-1:0] active);
        write_register(ADDR_BASE, base);
        write_register(ADDR_ACTIVE, 32'(active));
        n_settings++;
    endtask

    task automatic wait_idle();
        while (n_pushed != n_accepted || expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic send_request(logic kind, logic [31:0] size, logic [31:0] addr);
        req_t item;
        item.req_type = kind;
        item.request_size = size;
        item.free_address = addr;
        pending_req.push_back(item);
        n_pushed++;
    endtask

    task automatic send_random();
        int unsigned count;
        int unsigned need;
        int unsigned roll;
        int unsigned blk;
        int unsigned firsts [$];
        logic [31:0] size;
        logic [31:0] addr;
        count = table_count();
        size = $urandom;
        addr = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                size = '0;
            end
            else if (roll >= 16)
            begin
                need = (roll < 80) ? $urandom_range(1, 8) : $urandom_range(1, count + 2);
                size = need * BLOCK_BYTES - $urandom_range(0, BLOCK_BYTES - 1);
            end
            send_request(REQ_ALLOC, size, addr);
        end
        else
        begin
            for (int i = 0; i < count; i++)
            begin
                if (marks_model[i][MARK_FIRST_BIT])
                begin
                    firsts.push_back(i);
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 88)
            begin
                if (roll < 65 && firsts.size() > 0)
                begin
                    blk = firsts[$urandom_range(0, firsts.size() - 1)];
                end
                else
                begin
                    blk = $urandom_range(0, count);
                end
                addr = base_model + blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
            end
            send_request(REQ_FREE, size, addr);
        end
    endtask

    task automatic run_random(int items, bit drain_midway);
        for (int k = 0; k < items; k++)
        begin
            while (pending_req.size() != 0)
            begin
                @(posedge clk);
            end
            if (drain_midway && k == items / 2)
            begin
                wait_idle();
            end
            send_random();
        end
        wait_idle();
    endtask

    initial
    begin
        logic [31:0] heap_b;
        heap_b = 32'h4000_0000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_heap(32'h0, 11'd2047);
        send_request(REQ_ALLOC, 32'(NUM_BLOCKS * BLOCK_BYTES), $urandom);
        send_request(REQ_ALLOC, 32'd1, $urandom);
        wait_idle();
        set_heap(32'h0, 11'd4);
        send_request(REQ_FREE, $urandom, 32'h0);
        wait_idle();
        set_heap(heap_b, 11'd8);
        send_request(REQ_ALLOC, 32'd0, $urandom);
        send_request(REQ_ALLOC, 32'd1, $urandom);
        send_request(REQ_ALLOC, 32'(BLOCK_BYTES), $urandom);
        send_request(REQ_ALLOC, 32'(BLOCK_BYTES + 1), $urandom);
        send_request(REQ_ALLOC, 32'd1, $urandom);
        send_request(REQ_FREE, $urandom, heap_b + 5 * BLOCK_BYTES);
        send_request(REQ_FREE, $urandom, heap_b + 4 * BLOCK_BYTES + 100);
        send_request(REQ_FREE, $urandom, heap_b + 2 * BLOCK_BYTES + 123);
        send_request(REQ_FREE, $urandom, heap_b + 3 * BLOCK_BYTES);
        send_request(REQ_FREE, $urandom, heap_b - 1);
        send_request(REQ_FREE, $urandom, heap_b + 8 * BLOCK_BYTES);
        send_request(REQ_ALLOC, 32'(3 * BLOCK_BYTES), $urandom);
        send_request(REQ_ALLOC, 32'hffff_ffff, $urandom);
        send_request(REQ_ALLOC, 32'(4 * BLOCK_BYTES), $urandom);
        send_request(REQ_ALLOC, 32'(3 * BLOCK_BYTES), $urandom);
        send_request(REQ_FREE, $urandom, heap_b);
        wait_idle();
        set_heap(32'hffff_f000, 11'd1);
        send_request(REQ_ALLOC, 32'd1, $urandom);
        send_request(REQ_ALLOC, 32'd1, $urandom);
        send_request(REQ_FREE, $urandom, 32'hffff_f000);
        wait_idle();
        set_heap(32'hffff_ffff, 11'd0);
        send_request(REQ_ALLOC, 32'(BLOCK_BYTES), $urandom);
        send_request(REQ_FREE, $urandom, 32'hffff_ffff);
        wait_idle();

        set_heap($urandom & 32'(~(BLOCK_BYTES - 1)), 11'd16);
        run_random(64, 1'b0);
        steady = 1'b1;
        set_heap(32'h0, 11'd64);
        run_random(64, 1'b1);
        steady = 1'b0;
        set_heap($urandom, 11'($urandom_range(2, 32)));
        run_random(64, 1'b0);
        set_heap(32'hfff0_0000, ACTIVE_RESET);
        run_random(64, 1'b0);

        repeat (100) @(posedge clk);
        $display("Ran %0d requests over %0d register settings: %0d grants, %0d refusals,",
            n_accepted, n_settings, n_granted, n_refused);
        $display("%0d frees inside the table and %0d outside; %0d result words, %0d mismatches.",
            n_freed, n_outside, n_results, n_mismatch);
        if (n_mismatch == 0 && expected_rsp.size() == 0)
        begin
            $display("block_table_heap_allocator test passed");
        end
        else
        begin
            $display("block_table_heap_allocator test failed");
        end
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Timeout with %0d results outstanding.", expected_rsp.size());
        $display("block_table_heap_allocator test failed");
        $finish;
    end

endmodule
`default_nettype wire
